[rtl/jkv_pkg.sv]
// Shared types and constants of the JSON key/value extractor.
// Holds character codes, number limits, key storage sizes, register indexes, stream packing widths and the result type.
// No dependencies.
package jkv_pkg;

  // Character codes used by the pattern match and the value scanner.
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned DECIMAL_BASE = 10;
  localparam logic [30:0] NUM_MAX      = 31'h7FFF_FFFF;

  // Key storage: six 64-bit words, first key byte in the lowest byte.
  localparam int unsigned KEY_WORDS    = 6;
  localparam int unsigned KEY_CAPACITY = KEY_WORDS * 8;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_LENGTH   = 3'd0;
  localparam logic [2:0] REG_KEY_CHARS_0  = 3'd1;
  localparam logic [2:0] REG_KEY_CHARS_5  = 3'd6;
  localparam logic [2:0] REG_STRING_LIMIT = 3'd7;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // Result stream packing.
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef struct packed {
    logic [7:0]  value_length;
    logic        number_overflow;
    logic [30:0] number_value;
    logic        is_number;
    logic        found;
    logic        final_res;
    logic        char_valid;
    logic [7:0]  value_char;
  } result_t;

endpackage

[rtl/json_key_value_extractor_unit.sv]
// Streaming JSON flat key lookup: top level.
// Depends on jkv_pkg for character codes, register indexes and the result type.
//
// The block takes one document byte per clock cycle and gives up to two results for it
// (a value byte and the closing result) into a four-entry output queue. The key compare
// over the byte window and the decimal accumulation each finish in the cycle the byte is
// taken, so the rate is one byte per cycle; in_tready drops only while the queue has fewer
// than two free entries, and in the cycle after reset and after each configuration
// request while the aligned compare pattern is rebuilt from the key registers. No
// clearing pass is needed after reset.
module json_key_value_extractor_unit
  import jkv_pkg::*;
#(
  parameter int unsigned KEY_MAX = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Document byte stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] doc_char
  input  logic                   in_tlast,   // end_of_doc
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] value_char, [8] found, [39:9] number_value, [40] number_overflow,
  // [48:41] value_length, [55:49] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] char_valid, [1] is_number
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast   // final_res
);

  localparam int unsigned WIN     = KEY_MAX + 3;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_STRING,
    PH_NUMBER,
    PH_DONE
  } phase_t;

  // Configuration registers
  logic [5:0]                  key_length_r;
  logic [KEY_WORDS-1:0][63:0]  key_r;
  logic [7:0]                  string_limit_r;
  logic                        cfg_busy_r;
  logic [KEY_WORDS*64-1:0]     key_flat;

  // Compare pattern aligned to window age
  logic [7:0] exp_r   [2:WIN-1];
  logic [7:0] exp_nxt [2:WIN-1];
  logic [WIN-1:2] care_r, care_nxt;

  // Document state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  recent_r   [0:WIN-2];
  logic [5:0]  seen_r, seen_nxt;
  logic [7:0]  emitted_r, emitted_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;

  // Output queue
  result_t          q_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0]  head_r, tail_r;
  logic [Q_CW-1:0]  count_r;

  logic        in_acc, out_pop;
  logic [7:0]  c;
  logic        eod;
  logic        is_blank, is_digit, is_quote;
  logic        win_hit;
  logic [5:0]  lenc;
  logic [6:0]  len7;
  logic [34:0] dec_sum;
  logic [30:0] acc_add;
  logic        ovf_add;
  logic        want_char, push_char, push_final, final_found, final_num;
  logic        do_digit;
  result_t     res_char, res_final, res0, res1;
  logic [1:0]  push_n;

  assign cfg_ready = 1'b1;
  assign key_flat  = key_r;
  assign in_tready = !cfg_busy_r && (count_r <= Q_CW'(Q_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_pop    = out_tvalid && out_tready;

  assign c   = in_tdata;
  assign eod = in_tlast;

  assign lenc = (key_length_r > 6'(KEY_MAX)) ? 6'(KEY_MAX) : key_length_r;
  assign len7 = {1'b0, lenc};

  // Pattern for window age k: age 0 is the colon, age 1 the closing quote,
  // the key runs backwards from age 2 and its opening quote sits at len+2.
  always_comb begin
    logic [6:0] kk;
    logic [6:0] idx;
    for (int k = 2; k < WIN; k++) begin
      kk          = 7'(k);
      idx         = len7 + 7'd1 - kk;
      care_nxt[k] = (kk <= len7 + 7'd2);
      if (kk == len7 + 7'd2) begin
        exp_nxt[k] = CHAR_QUOTE;
      end else if (idx < 7'(KEY_CAPACITY)) begin
        exp_nxt[k] = key_flat[{idx[5:0], 3'b000} +: 8];
      end else begin
        exp_nxt[k] = 8'h00;
      end
    end
  end

  // Window match against the window as it stands after this byte is shifted in.
  always_comb begin
    logic [WIN-1:2] hit;
    for (int k = 2; k < WIN; k++) begin
      hit[k] = !care_r[k] || (recent_r[k-1] == exp_r[k]);
    end
    win_hit = (c == CHAR_COLON) && (recent_r[0] == CHAR_QUOTE) && (&hit) &&
              ({1'b0, seen_nxt} >= len7 + 7'd3);
  end

  assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
                    (c == CHAR_CR);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_quote = (c == CHAR_QUOTE);

  // Decimal accumulation with saturation.
  assign dec_sum = 35'(acc_r) * 35'(DECIMAL_BASE) + 35'(c - CHAR_ZERO);
  assign ovf_add = (dec_sum > 35'(NUM_MAX));
  assign acc_add = ovf_add ? NUM_MAX : dec_sum[30:0];

  always_comb begin
    phase_nxt   = phase_r;
    seen_nxt    = seen_r;
    want_char   = 1'b0;
    push_final  = 1'b0;
    final_found = 1'b0;
    final_num   = 1'b0;
    do_digit    = 1'b0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (seen_r != 6'h3F) seen_nxt = seen_r + 6'd1;
        if (win_hit) phase_nxt = PH_SKIP;
        push_final = eod;
      end
      PH_SKIP: begin
        if (is_blank) begin
          push_final = eod;
        end else if (is_quote) begin
          phase_nxt   = PH_STRING;
          push_final  = eod;
          final_found = 1'b1;
        end else if (is_digit) begin
          phase_nxt   = PH_NUMBER;
          do_digit    = 1'b1;
          want_char   = 1'b1;
          push_final  = eod;
          final_found = 1'b1;
          final_num   = 1'b1;
        end else begin
          push_final = 1'b1;
        end
      end
      PH_STRING: begin
        final_found = 1'b1;
        if (is_quote) begin
          push_final = 1'b1;
        end else begin
          want_char  = 1'b1;
          push_final = eod;
        end
      end
      PH_NUMBER: begin
        final_found = 1'b1;
        final_num   = 1'b1;
        if (is_digit) begin
          do_digit   = 1'b1;
          want_char  = 1'b1;
          push_final = eod;
        end else begin
          push_final = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (push_final) phase_nxt = PH_DONE;

    push_char   = want_char && (emitted_r < string_limit_r);
    emitted_nxt = emitted_r + (push_char ? 8'd1 : 8'd0);
    acc_nxt     = do_digit ? acc_add : acc_r;
    ovf_nxt     = ovf_r || (do_digit && ovf_add);
  end

  always_comb begin
    res_char            = '0;
    res_char.value_char = c;
    res_char.char_valid = 1'b1;

    res_final           = '0;
    res_final.final_res = 1'b1;
    if (final_found) begin
      res_final.found           = 1'b1;
      res_final.is_number       = final_num;
      res_final.number_value    = final_num ? acc_nxt : 31'd0;
      res_final.number_overflow = final_num && ovf_nxt;
      res_final.value_length    = emitted_nxt;
    end

    res0   = push_char ? res_char : res_final;
    res1   = res_final;
    push_n = in_acc ? (2'(push_char) + 2'(push_final)) : 2'd0;
  end

  assign out_tdata = {7'd0, q_r[head_r].value_length, q_r[head_r].number_overflow,
                      q_r[head_r].number_value, q_r[head_r].found,
                      q_r[head_r].value_char};
  assign out_tuser = {q_r[head_r].is_number, q_r[head_r].char_valid};
  assign out_tlast = q_r[head_r].final_res;

  always_ff @(posedge clk) begin
    exp_r  <= exp_nxt;
    care_r <= care_nxt;

    if (!rst_n) begin
      key_length_r   <= 6'd1;
      key_r          <= '0;
      string_limit_r <= 8'd63;
      cfg_busy_r     <= 1'b1;
      phase_r        <= PH_SEARCH;
      seen_r         <= '0;
      emitted_r      <= '0;
      acc_r          <= '0;
      ovf_r          <= 1'b0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
    end else begin
      cfg_busy_r <= cfg_valid;
      if (cfg_valid) begin
        unique case (cfg_index) inside
          REG_KEY_LENGTH: key_length_r <= cfg_data[5:0];
          [REG_KEY_CHARS_0:REG_KEY_CHARS_5]: key_r[cfg_index - REG_KEY_CHARS_0] <= cfg_data;
          REG_STRING_LIMIT: string_limit_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        if (eod) begin
          phase_r   <= PH_SEARCH;
          seen_r    <= '0;
          emitted_r <= '0;
          acc_r     <= '0;
          ovf_r     <= 1'b0;
        end else begin
          phase_r   <= phase_nxt;
          seen_r    <= seen_nxt;
          emitted_r <= emitted_nxt;
          acc_r     <= acc_nxt;
          ovf_r     <= ovf_nxt;
        end
      end

      tail_r  <= tail_r + Q_AW'(push_n);
      head_r  <= head_r + Q_AW'(out_pop);
      count_r <= count_r + Q_CW'(push_n) - Q_CW'(out_pop);
    end

    // The window only shifts while searching; stale bytes are masked by the fill count.
    if (in_acc && phase_r == PH_SEARCH) begin
      recent_r[0] <= c;
      for (int k = 1; k < WIN - 1; k++) begin
        recent_r[k] <= recent_r[k-1];
      end
    end

    if (push_n != 2'd0) q_r[tail_r] <= res0;
    if (push_n == 2'd2) q_r[tail_r + Q_AW'(1)] <= res1;
  end

endmodule

[rtl/jkv_checker.sv]
// Port-level checks for the JSON key/value extractor, bound to its top level.
// Depends on jkv_pkg for the stream and configuration widths.
module jkv_checker
  import jkv_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [7:0]             in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A value byte result is never also the closing result.
  a_char_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast && !out_tuser[1] &&
    (out_tdata[OUT_TDATA_W-1:8] == '0))
    else $error("value byte result carries closing fields");

  // A not-found closing result reports no value.
  a_notfound_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tdata[8] |-> !out_tuser[1] &&
    (out_tdata[OUT_TDATA_W-1:9] == '0))
    else $error("not-found result carries value fields");

  // A string result has no number fields.
  a_string_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser[1] |-> (out_tdata[40:9] == '0))
    else $error("string result carries a number");

  // The compare pattern is rebuilt after a configuration request.
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input taken right after a configuration request");

endmodule

bind json_key_value_extractor_unit jkv_checker u_jkv_checker (.*);
